FILE: rtl/tkmh_pkg.sv
package tkmh_pkg;

    localparam int HEAP_DEPTH  = 1024;
    localparam int VAL_W       = 32;
    localparam int FIELD_W     = 11;
    localparam int ADDR_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int IDX_W       = ADDR_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_OFFER = 1'b0,
        OP_POP   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_POP_RD = 5'b00010,
        S_UP     = 5'b00100,
        S_DOWN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

FILE: rtl/tkmh_if.sv
interface tkmh_req_if
    import tkmh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [0:0]              req_type;
    logic signed [VAL_W-1:0] offered_value;

    modport source (output valid, output req_type, output offered_value, input ready);
    modport sink   (input valid, input req_type, input offered_value, output ready);
endinterface

interface tkmh_rsp_if
    import tkmh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [0:0]              accepted;
    logic signed [VAL_W-1:0] popped_value;
    logic signed [VAL_W-1:0] smallest_kept;
    logic [FIELD_W-1:0]      kept_count;
    logic [0:0]              empty_error;

    modport source (output valid, output accepted, output popped_value,
                    output smallest_kept, output kept_count, output empty_error,
                    input ready);
    modport sink   (input valid, input accepted, input popped_value,
                    input smallest_kept, input kept_count, input empty_error,
                    output ready);
endinterface

FILE: rtl/tkmh_front.sv
module tkmh_front
    import tkmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkmh_req_if.sink    i_req,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QFILL_W-1:0] r_fill,   n_fill;
    logic               push;
    logic               pop;
    t_cmd               in_cmd;

    assign i_req.ready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        in_cmd.op    = t_op'(i_req.req_type);
        in_cmd.value = i_req.offered_value;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

FILE: rtl/tkmh_heap_engine.sv
module tkmh_heap_engine
    import tkmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_take,
    tkmh_rsp_if.source         o_rsp
);

    logic signed [VAL_W-1:0] heap_mem [HEAP_DEPTH];

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CMP_W-1:0]        r_limit;
    logic [ADDR_W-1:0]       r_idx,   n_idx;
    logic signed [VAL_W-1:0] r_val,   n_val;
    logic signed [VAL_W-1:0] r_root,  n_root;
    logic                    r_acc,   n_acc;
    logic                    r_err,   n_err;
    logic signed [VAL_W-1:0] r_pop,   n_pop;
    logic                    r_out_valid, n_out_valid;

    logic signed [VAL_W-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic [0:0]              r_rsp_acc;
    logic signed [VAL_W-1:0] r_rsp_pop;
    logic signed [VAL_W-1:0] r_rsp_root;
    logic [FIELD_W-1:0]      r_rsp_cnt;
    logic [0:0]              r_rsp_err;

    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        eff_limit;
    logic [IDX_W-1:0]        left_i, right_i, n_ext;
    logic                    left_ok, right_ok;
    logic signed [VAL_W-1:0] small_v;
    logic [ADDR_W-1:0]       par_idx;

    function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] idx);
        left_of = (IDX_W'(idx) << 1) + IDX_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] dec;
        dec       = idx - 1'b1;
        parent_of = dec >> 1;
    endfunction

    assign cnt_ext = CMP_W'(r_count);
    assign n_ext   = IDX_W'(r_count);

    always_comb begin
        if (r_limit == '0) begin
            eff_limit = CMP_W'(1);
        end else if (r_limit > CMP_W'(HEAP_DEPTH)) begin
            eff_limit = CMP_W'(HEAP_DEPTH);
        end else begin
            eff_limit = r_limit;
        end
    end

    assign left_i   = left_of(r_idx);
    assign right_i  = left_i + IDX_W'(1);
    assign left_ok  = (left_i < n_ext) && (r_rd_a < r_val);
    assign small_v  = left_ok ? r_rd_a : r_val;
    assign right_ok = (right_i < n_ext) && (r_rd_b < small_v);
    assign par_idx  = parent_of(r_idx);

    always_comb begin
        logic [ADDR_W-1:0] best;
        logic [IDX_W-1:0]  best_l;
        best        = '0;
        best_l      = '0;
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_root      = r_root;
        n_acc       = r_acc;
        n_err       = r_err;
        n_pop       = r_pop;
        n_out_valid = r_out_valid && !o_rsp.ready;
        o_cmd_take  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_val;
        rd_addr_a   = '0;
        rd_addr_b   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_take = 1'b1;
                    n_acc      = 1'b0;
                    n_err      = 1'b0;
                    n_pop      = '0;
                    n_val      = i_cmd.value;
                    case (i_cmd.op)
                        OP_OFFER: begin
                            if (cnt_ext < eff_limit) begin
                                n_acc   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (r_count == '0) begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data = i_cmd.value;
                                    n_root  = i_cmd.value;
                                    n_state = S_DONE;
                                end else begin
                                    n_idx     = ADDR_W'(r_count);
                                    rd_addr_a = parent_of(ADDR_W'(r_count));
                                    n_state   = S_UP;
                                end
                            end else if (i_cmd.value > r_root) begin
                                n_acc     = 1'b1;
                                n_idx     = '0;
                                best_l    = left_of('0);
                                rd_addr_a = best_l[ADDR_W-1:0];
                                rd_addr_b = ADDR_W'(best_l + IDX_W'(1));
                                n_state   = S_DOWN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_err   = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_pop   = r_root;
                                n_count = r_count - 1'b1;
                                if (r_count == CNT_W'(1)) begin
                                    n_state = S_DONE;
                                end else begin
                                    rd_addr_a = ADDR_W'(r_count - 1'b1);
                                    n_state   = S_POP_RD;
                                end
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_val     = r_rd_a;
                n_idx     = '0;
                best_l    = left_of('0);
                rd_addr_a = best_l[ADDR_W-1:0];
                rd_addr_b = ADDR_W'(best_l + IDX_W'(1));
                n_state   = S_DOWN;
            end
            S_UP: begin
                wr_en = 1'b1;
                if (r_idx == '0) begin
                    wr_data = r_val;
                    n_root  = r_val;
                    n_state = S_DONE;
                end else if (r_rd_a > r_val) begin
                    wr_data   = r_rd_a;
                    n_idx     = par_idx;
                    rd_addr_a = parent_of(par_idx);
                end else begin
                    wr_data = r_val;
                    n_state = S_DONE;
                end
            end
            S_DOWN: begin
                wr_en = 1'b1;
                if (right_ok) begin
                    wr_data = r_rd_b;
                    best    = right_i[ADDR_W-1:0];
                end else if (left_ok) begin
                    wr_data = r_rd_a;
                    best    = left_i[ADDR_W-1:0];
                end else begin
                    wr_data = r_val;
                    n_state = S_DONE;
                end
                if (r_idx == '0) begin
                    n_root = wr_data;
                end
                if (right_ok || left_ok) begin
                    n_idx     = best;
                    best_l    = left_of(best);
                    rd_addr_a = best_l[ADDR_W-1:0];
                    rd_addr_b = ADDR_W'(best_l + IDX_W'(1));
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= CMP_W'(HEAP_DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= CMP_W'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_root <= n_root;
        r_acc  <= n_acc;
        r_err  <= n_err;
        r_pop  <= n_pop;
        if (r_state == S_DONE) begin
            r_rsp_acc  <= r_acc;
            r_rsp_pop  <= r_pop;
            r_rsp_root <= (r_count != '0) ? r_root : '0;
            r_rsp_cnt  <= cnt_ext[FIELD_W-1:0];
            r_rsp_err  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= heap_mem[rd_addr_a];
        r_rd_b <= heap_mem[rd_addr_b];
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.accepted      = r_rsp_acc;
    assign o_rsp.popped_value  = r_rsp_pop;
    assign o_rsp.smallest_kept = r_rsp_root;
    assign o_rsp.kept_count    = r_rsp_cnt;
    assign o_rsp.empty_error   = r_rsp_err;

endmodule

FILE: rtl/top_k_min_heap_selector_core.sv
// channel   | role   | handshake     | payload
// i_req     | sink   | valid / ready | req_type, offered_value
// o_rsp     | source | valid / ready | accepted, popped_value, smallest_kept,
//           |        |               | kept_count, empty_error
// cfg       | write  | i_cfg_we      | i_cfg_wdata (kept_limit)
//
// An item needs no heap walk for a first offer, a dropped offer, or a pop of the
// last entry or of an empty heap. An insert walks up, a root replacement walks
// down, and a pop reads the last entry and walks down, at most 9 levels here,
// one heap level per cycle through the two-read, one-write heap memory.
// A two-entry command queue takes requests while a result waits in o_rsp.
// Synchronous active-low reset empties the heap and sets kept_limit to the depth.
module top_k_min_heap_selector_core
    import tkmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    tkmh_req_if.sink           i_req,
    tkmh_rsp_if.source         o_rsp
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    tkmh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    tkmh_heap_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: test/tkmh_checker.sv
`timescale 1ns / 100ps

module tkmh_checker
    import tkmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    tkmh_req_if                i_req,
    tkmh_rsp_if                i_rsp,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic                    accepted;
        logic signed [VAL_W-1:0] popped_value;
        logic signed [VAL_W-1:0] smallest_kept;
        logic [FIELD_W-1:0]      kept_count;
        logic                    empty_error;
    } t_outcome;

    logic signed [VAL_W-1:0] kept_heap [HEAP_DEPTH];
    int unsigned             kept_total    = 0;
    logic [FIELD_W-1:0]      limit_reg     = FIELD_W'(HEAP_DEPTH);
    t_outcome                due_outcomes[$];
    int                      fail_total    = 0;
    int                      checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_outcomes.size();
    assign o_checked    = checked_total;

    function automatic void swap_entries(input int unsigned a, input int unsigned b);
        logic signed [VAL_W-1:0] held;
        held         = kept_heap[a];
        kept_heap[a] = kept_heap[b];
        kept_heap[b] = held;
    endfunction

    // Left child wins ties; right child only when strictly smaller.
    function automatic void lower_root(input int unsigned n);
        int unsigned i;
        int unsigned best;
        int unsigned l;
        int unsigned r;
        i = 0;
        while (1'b1) begin
            best = i;
            l    = 2 * i + 1;
            r    = 2 * i + 2;
            if (l < n && kept_heap[l] < kept_heap[best]) best = l;
            if (r < n && kept_heap[r] < kept_heap[best]) best = r;
            if (best == i) break;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic void raise_entry(input int unsigned start);
        int unsigned i;
        int unsigned parent;
        i = start;
        while (i > 0) begin
            parent = (i - 1) / 2;
            if (kept_heap[parent] <= kept_heap[i]) break;
            swap_entries(parent, i);
            i = parent;
        end
    endfunction

    function automatic t_outcome apply_to_heap(input t_op op,
                                               input logic signed [VAL_W-1:0] value);
        t_outcome    res;
        int unsigned cap;
        res = '0;
        if (limit_reg == 0) begin
            cap = 1;
        end else if (limit_reg > HEAP_DEPTH) begin
            cap = HEAP_DEPTH;
        end else begin
            cap = limit_reg;
        end
        if (op == OP_OFFER) begin
            if (kept_total < cap) begin
                kept_heap[kept_total] = value;
                raise_entry(kept_total);
                kept_total++;
                res.accepted = 1'b1;
            end else if (value > kept_heap[0]) begin
                kept_heap[0] = value;
                lower_root(kept_total);
                res.accepted = 1'b1;
            end
        end else if (kept_total == 0) begin
            res.empty_error = 1'b1;
        end else begin
            res.popped_value = kept_heap[0];
            kept_total--;
            kept_heap[0] = kept_heap[kept_total];
            lower_root(kept_total);
        end
        if (kept_total > 0) res.smallest_kept = kept_heap[0];
        res.kept_count = kept_total[FIELD_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string field,
                                        input logic signed [VAL_W:0] want,
                                        input logic signed [VAL_W:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome due;
        if (!i_rst_n) begin
            kept_total = 0;
            limit_reg  = FIELD_W'(HEAP_DEPTH);
            due_outcomes.delete();
        end else begin
            if (i_cfg_we) limit_reg = i_cfg_wdata;
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                due_outcomes.push_back(apply_to_heap(t_op'(i_req.req_type),
                                                     i_req.offered_value));
            end
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (due_outcomes.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_total++;
                end else begin
                    due = due_outcomes.pop_front();
                    check_field("accepted", due.accepted, i_rsp.accepted);
                    check_field("popped_value", due.popped_value, i_rsp.popped_value);
                    check_field("smallest_kept", due.smallest_kept, i_rsp.smallest_kept);
                    check_field("kept_count", due.kept_count, i_rsp.kept_count);
                    check_field("empty_error", due.empty_error, i_rsp.empty_error);
                    checked_total++;
                end
            end
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tkmh_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [FIELD_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int sent_total    = 0;
    int setting_total = 0;
    int req_gap_max   = 4;
    int rsp_gap_max   = 4;

    tkmh_req_if req_ch ();
    tkmh_rsp_if rsp_ch ();

    top_k_min_heap_selector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    tkmh_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        forever begin
            stall = $urandom_range(rsp_gap_max, 0);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic send_req(input t_op op, input logic signed [VAL_W-1:0] value);
        int gap;
        gap = $urandom_range(req_gap_max, 0);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.offered_value <= value;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sent_total++;
    endtask

    // Hold off until every result is back and the block has settled.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(input int limit);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= FIELD_W'(limit);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        setting_total++;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(3, 0))
            0: return $urandom_range(8, 0) - 4;
            1: begin
                case ($urandom_range(3, 0))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return VAL_MAX - $urandom_range(3, 0);
                    default: return VAL_MIN + $urandom_range(3, 0);
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(input int limit, input int items,
                             input int pop_pct, input int req_max, input int rsp_max);
        t_op op;
        set_limit(limit);
        req_gap_max = req_max;
        rsp_gap_max = rsp_max;
        repeat (items) begin
            op = ($urandom_range(99, 0) < pop_pct) ? OP_POP : OP_OFFER;
            send_req(op, pick_value());
        end
    endtask

    initial begin
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= OP_OFFER;
        req_ch.offered_value <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pop, extremes, drain in order
        send_req(OP_POP, VAL_MAX);
        send_req(OP_OFFER, VAL_MAX);
        send_req(OP_OFFER, VAL_MIN);
        send_req(OP_OFFER, '0);
        send_req(OP_OFFER, -1);
        repeat (4) send_req(OP_POP, $urandom());

        // single slot: equal and smaller drop, larger replaces
        set_limit(1);
        send_req(OP_OFFER, 5);
        send_req(OP_OFFER, 5);
        send_req(OP_OFFER, 3);
        send_req(OP_OFFER, 9);
        send_req(OP_POP, '0);
        send_req(OP_POP, '0);

        // zero limit acts as one
        set_limit(0);
        send_req(OP_OFFER, 7);
        send_req(OP_OFFER, 8);
        send_req(OP_POP, '0);

        // lower limit below count, then drop, replace root and pop twice
        set_limit(4);
        send_req(OP_OFFER, 1);
        send_req(OP_OFFER, 2);
        send_req(OP_OFFER, 3);
        send_req(OP_OFFER, 4);
        set_limit(2);
        send_req(OP_OFFER, 0);
        send_req(OP_OFFER, 50);
        send_req(OP_POP, '0);
        send_req(OP_POP, '0);

        run_phase(1, 60, 30, 16, 16);
        run_phase(0, 40, 30, 3, 0);
        run_phase(5, 120, 25, 16, 16);
        run_phase(16, 150, 20, 0, 0);
        run_phase(3, 80, 50, 16, 4);
        run_phase(64, 200, 40, 8, 16);
        run_phase(2047, 150, 0, 2, 2);
        run_phase(1024, 80, 50, 16, 16);

        wait_idle();
        $display("Sent %0d requests over %0d kept_limit settings (0, 1, small, 1024, 2047),",
                 sent_total, setting_total);
        $display("with drops, root replacements, empty pops and a lowered limit; %0d checked.",
                 checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tkmh_pkg.sv
rtl/tkmh_if.sv
rtl/tkmh_front.sv
rtl/tkmh_heap_engine.sv
rtl/top_k_min_heap_selector_core.sv
test/tkmh_checker.sv
test/tb_top.sv
